@@ hw/rtl/chtab_pkg.sv @@
// shared types and codes for the channel hit table
// used by chtab_front, chtab_queue, chtab_back and top_channel_hit_table

package chtab_pkg;

  // item kind codes on the input channel
  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // queue between front and back
  localparam int QDEPTH = 2;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_RECORD = 3'd0,
    OP_SKIP   = 3'd1,
    OP_READ   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_NOP    = 3'd4
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [11:0] mhz;
    logic [15:0] packets;
    logic [6:0]  rssi;
    logic [1:0]  rate;
    logic [3:0]  idx;
  } cmd_t;

  // one table slot
  typedef struct packed {
    logic [11:0] mhz;
    logic [15:0] packets;
    logic [6:0]  rssi;
    logic [1:0]  rate;
  } entry_t;

endpackage

@@ hw/rtl/chtab_front.sv @@
// front end: accepts input items and classifies them into commands
// depends on chtab_pkg

module chtab_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [11:0]       in_channel_mhz,
  input  logic [15:0]       in_packet_count,
  input  logic [6:0]        in_signal_rssi,
  input  logic [1:0]        in_data_rate,
  input  logic [3:0]        in_entry_index,
  output logic              push_valid,
  input  logic              push_ready,
  output chtab_pkg::cmd_t   push_cmd
);
  import chtab_pkg::*;

  op_t op;

  // a record with no packets touches nothing; kind three does nothing
  always_comb begin
    unique case (in_kind)
      KIND_RECORD: op = (in_packet_count != 16'd0) ? OP_RECORD : OP_SKIP;
      KIND_READ:   op = OP_READ;
      KIND_CLEAR:  op = OP_CLEAR;
      default:     op = OP_NOP;
    endcase
  end

  // an item is taken whenever the queue has room
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  assign push_cmd = '{op: op, mhz: in_channel_mhz, packets: in_packet_count,
                      rssi: in_signal_rssi, rate: in_data_rate, idx: in_entry_index};

endmodule

@@ hw/rtl/chtab_queue.sv @@
// short command queue between front and back
// depends on chtab_pkg

module chtab_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  chtab_pkg::cmd_t   push_cmd,
  output logic              pop_valid,
  input  logic              pop,
  output chtab_pkg::cmd_t   pop_cmd
);
  import chtab_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             slot_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/chtab_back.sv @@
// back end: slot memory, scan sequencer, running total and result register
// depends on chtab_pkg

module chtab_back #(
  parameter int MAX_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  chtab_pkg::cmd_t   q_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_entry_valid,
  output logic [11:0]       out_mhz,
  output logic [15:0]       out_packets,
  output logic [6:0]        out_rssi,
  output logic [1:0]        out_rate,
  output logic [4:0]        out_hit_count,
  output logic [31:0]       out_hit_total
);
  import chtab_pkg::*;

  localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RDWAIT = 4'b0010,
    S_MATCH  = 4'b0100,
    S_WEAK   = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [31:0]       total_r, total_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [ADDR_W-1:0] cmp_ptr_r, cmp_ptr_nxt;
  logic              best_vld_r, best_vld_nxt;
  logic [15:0]       best_pk_r, best_pk_nxt;
  logic [ADDR_W-1:0] best_idx_r, best_idx_nxt;

  entry_t            mem_r [MAX_SLOTS];
  entry_t            rd_q_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;

  logic              res_load;
  logic              res_valid;
  entry_t            res_entry;

  logic              out_valid_r, out_valid_nxt;
  logic              out_ev_r;
  entry_t            out_entry_r;
  logic [4:0]        out_cnt_r;
  logic [31:0]       out_total_r;
  logic [31:0]       used_w;

  // sequencer
  always_comb begin
    logic [31:0] idx_w;
    logic [16:0] sum;
    entry_t      fresh;
    entry_t      merged;

    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    used_nxt     = used_r;
    total_nxt    = total_r;
    ptr_nxt      = ptr_r;
    cmp_vld_nxt  = 1'b0;
    cmp_ptr_nxt  = cmp_ptr_r;
    best_vld_nxt = best_vld_r;
    best_pk_nxt  = best_pk_r;
    best_idx_nxt = best_idx_r;
    rd_addr      = '0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    res_load     = 1'b0;
    res_valid    = 1'b0;
    res_entry    = '0;
    q_pop        = 1'b0;

    idx_w  = 32'(q_cmd.idx);
    fresh  = '{mhz: cmd_r.mhz, packets: cmd_r.packets, rssi: cmd_r.rssi, rate: cmd_r.rate};
    sum    = {1'b0, rd_q_r.packets} + {1'b0, cmd_r.packets};
    merged = rd_q_r;
    merged.packets = sum[16] ? 16'hFFFF : sum[15:0];
    if (cmd_r.rssi < rd_q_r.rssi) begin
      merged.rssi = cmd_r.rssi;
    end

    unique case (state_r)
      S_IDLE: begin
        // take one command at a time, only while the result register is free
        if (q_valid && !out_valid_r) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          unique case (q_cmd.op)
            OP_RECORD: begin
              total_nxt   = total_r + 32'(q_cmd.packets);
              ptr_nxt     = '0;
              state_nxt   = S_MATCH;
            end
            OP_READ: begin
              if (idx_w < 32'(used_r) && idx_w < 32'(MAX_SLOTS)) begin
                rd_addr   = idx_w[ADDR_W-1:0];
                state_nxt = S_RDWAIT;
              end else begin
                res_load  = 1'b1;
              end
            end
            OP_CLEAR: begin
              used_nxt  = '0;
              total_nxt = '0;
              res_load  = 1'b1;
            end
            default: begin
              res_load  = 1'b1;
            end
          endcase
        end
      end

      S_RDWAIT: begin
        res_load  = 1'b1;
        res_valid = 1'b1;
        res_entry = rd_q_r;
        state_nxt = S_IDLE;
      end

      S_MATCH: begin
        // issue one read per cycle, compare the one issued the cycle before
        if (ptr_r < used_r) begin
          rd_addr     = ptr_r[ADDR_W-1:0];
          ptr_nxt     = ptr_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_ptr_nxt = ptr_r[ADDR_W-1:0];
        end
        if (cmp_vld_r && rd_q_r.mhz == cmd_r.mhz) begin
          mem_we      = 1'b1;
          mem_waddr   = cmp_ptr_r;
          mem_wdata   = merged;
          res_load    = 1'b1;
          res_valid   = 1'b1;
          res_entry   = merged;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end else if (!cmp_vld_r && ptr_r >= used_r) begin
          if (32'(used_r) < 32'(MAX_SLOTS)) begin
            // room left: append
            mem_we    = 1'b1;
            mem_waddr = used_r[ADDR_W-1:0];
            mem_wdata = fresh;
            used_nxt  = used_r + 1'b1;
            res_load  = 1'b1;
            res_valid = 1'b1;
            res_entry = fresh;
            state_nxt = S_IDLE;
          end else begin
            // full: look for the first weakest slot
            ptr_nxt      = '0;
            cmp_vld_nxt  = 1'b0;
            best_vld_nxt = 1'b0;
            state_nxt    = S_WEAK;
          end
        end
      end

      S_WEAK: begin
        if (ptr_r < CNT_W'(MAX_SLOTS)) begin
          rd_addr     = ptr_r[ADDR_W-1:0];
          ptr_nxt     = ptr_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_ptr_nxt = ptr_r[ADDR_W-1:0];
        end
        // strict compare keeps the first of equal minimums
        if (cmp_vld_r && (!best_vld_r || rd_q_r.packets < best_pk_r)) begin
          best_vld_nxt = 1'b1;
          best_pk_nxt  = rd_q_r.packets;
          best_idx_nxt = cmp_ptr_r;
        end
        if (!cmp_vld_r && ptr_r == CNT_W'(MAX_SLOTS)) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
          if (cmd_r.packets > best_pk_r) begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_r;
            mem_wdata = fresh;
            res_valid = 1'b1;
            res_entry = fresh;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      used_r     <= '0;
      total_r    <= '0;
      ptr_r      <= '0;
      cmp_vld_r  <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      total_r    <= total_nxt;
      ptr_r      <= ptr_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      best_vld_r <= best_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cmp_ptr_r  <= cmp_ptr_nxt;
    best_pk_r  <= best_pk_nxt;
    best_idx_r <= best_idx_nxt;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= mem_r[rd_addr];
  end

  // result register
  assign used_w = 32'(used_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_ev_r    <= res_valid;
      out_entry_r <= res_entry;
      out_cnt_r   <= used_w[4:0];
      out_total_r <= total_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_valid = out_ev_r;
  assign out_mhz         = out_entry_r.mhz;
  assign out_packets     = out_entry_r.packets;
  assign out_rssi        = out_entry_r.rssi;
  assign out_rate        = out_entry_r.rate;
  assign out_hit_count   = out_cnt_r;
  assign out_hit_total   = out_total_r;

endmodule

@@ hw/rtl/top_channel_hit_table.sv @@
// top level of the channel hit table: front, command queue and back
// depends on chtab_pkg, chtab_front, chtab_queue, chtab_back

// Keeps up to MAX_SLOTS busy channels with packet counts, best RSSI and rate,
// plus a running packet total. Every input item (record, read, clear) gives
// exactly one result item. Input items go into a two-entry command queue, so
// the input side keeps accepting while the back end works and a result waits,
// until the queue is full. The back end handles one item at a time against a
// slot memory with one write and one registered read per cycle. Clear, skipped
// records, unused kinds and reads past the count load the result register
// straight from the idle state; a read of a used slot first waits for the
// registered read; a record scans the used slots one read per cycle for a
// merge or append, and when the table is full a second pass over all slots
// finds the weakest entry. The back end takes a new item in the cycle after
// the previous result has left the output register. Slot memory needs no
// clearing after reset.

module top_channel_hit_table #(
  parameter int MAX_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [11:0] in_channel_mhz,
  input  logic [15:0] in_packet_count,
  input  logic [6:0]  in_signal_rssi,
  input  logic [1:0]  in_data_rate,
  input  logic [3:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_entry_valid,
  output logic [11:0] out_mhz,
  output logic [15:0] out_packets,
  output logic [6:0]  out_rssi,
  output logic [1:0]  out_rate,
  output logic [4:0]  out_hit_count,
  output logic [31:0] out_hit_total
);
  import chtab_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // accept and classify
  chtab_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_channel_mhz  (in_channel_mhz),
    .in_packet_count (in_packet_count),
    .in_signal_rssi  (in_signal_rssi),
    .in_data_rate    (in_data_rate),
    .in_entry_index  (in_entry_index),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_cmd        (push_cmd)
  );

  // command queue
  chtab_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  // table and results
  chtab_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_cmd           (q_cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_valid (out_entry_valid),
    .out_mhz         (out_mhz),
    .out_packets     (out_packets),
    .out_rssi        (out_rssi),
    .out_rate        (out_rate),
    .out_hit_count   (out_hit_count),
    .out_hit_total   (out_hit_total)
  );

`ifndef ASSERT_OFF
  // back end never takes a command while a result is still waiting
  a_pop_needs_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !out_valid)
    else $error("command taken while result register full");

  // the result register must not stay full across a pop
  a_pop_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !(out_valid && $past(out_valid)))
    else $error("result register not free after pop");

  // a valid entry implies a nonempty table that fits
  a_valid_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid && (MAX_SLOTS < 32) |->
      out_hit_count != 5'd0 && 32'(out_hit_count) <= 32'(MAX_SLOTS))
    else $error("valid entry with bad table count");
`endif

endmodule

@@ bench/top_channel_hit_table_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for top_channel_hit_table: random and directed items, in-order check
// depends on chtab_pkg and top_channel_hit_table

module top_channel_hit_table_tb;
  import chtab_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int N_SLOTS     = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int BATCH_ITEMS = 550;
  localparam int LONG_HOLD   = 250;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] mhz;
    logic [15:0] packets;
    logic [6:0]  rssi;
    logic [1:0]  rate;
    logic [3:0]  idx;
  } hit_item_t;

  typedef struct packed {
    logic        valid;
    logic [11:0] mhz;
    logic [15:0] packets;
    logic [6:0]  rssi;
    logic [1:0]  rate;
    logic [4:0]  count;
    logic [31:0] total;
  } hit_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_entry_valid;
  logic [11:0] out_mhz;
  logic [15:0] out_packets;
  logic [6:0]  out_rssi;
  logic [1:0]  out_rate;
  logic [4:0]  out_hit_count;
  logic [31:0] out_hit_total;

  hit_item_t   cur = '0;
  hit_item_t   pending[$];
  hit_report_t report_q[$];

  // mirror of the channel table
  entry_t      tbl_slot [N_SLOTS];
  int          tbl_used = 0;
  logic [31:0] tbl_total = '0;

  int bad = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int send_gap = 0;
  bit send_burst = 1'b0;
  int stall_left = 0;
  int stall_long = 0;
  bit rcv_burst = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  top_channel_hit_table #(
    .MAX_SLOTS(N_SLOTS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (cur.kind),
    .in_channel_mhz (cur.mhz),
    .in_packet_count(cur.packets),
    .in_signal_rssi (cur.rssi),
    .in_data_rate   (cur.rate),
    .in_entry_index (cur.idx),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_entry_valid(out_entry_valid),
    .out_mhz        (out_mhz),
    .out_packets    (out_packets),
    .out_rssi       (out_rssi),
    .out_rate       (out_rate),
    .out_hit_count  (out_hit_count),
    .out_hit_total  (out_hit_total)
  );

  // apply one item to the table mirror and return the result it should give
  function automatic hit_report_t table_update(hit_item_t it);
    hit_report_t r;
    int          hit_at;
    int          weakest;
    int          i;
    logic [16:0] sum;
    r = '0;
    hit_at = -1;
    case (it.kind)
      KIND_RECORD: begin
        if (it.packets != 0) begin
          tbl_total = tbl_total + it.packets;
          for (i = 0; i < tbl_used; i++) begin
            if (hit_at < 0 && tbl_slot[i].mhz == it.mhz) hit_at = i;
          end
          if (hit_at >= 0) begin
            // merge: saturating count, keep the stronger rssi
            sum = {1'b0, tbl_slot[hit_at].packets} + {1'b0, it.packets};
            tbl_slot[hit_at].packets = sum[16] ? 16'hFFFF : sum[15:0];
            if (it.rssi < tbl_slot[hit_at].rssi) tbl_slot[hit_at].rssi = it.rssi;
          end else if (tbl_used < N_SLOTS) begin
            hit_at = tbl_used;
            tbl_slot[hit_at] = '{it.mhz, it.packets, it.rssi, it.rate};
            tbl_used++;
          end else begin
            // full table: first slot with the fewest packets, replaced only if beaten
            weakest = 0;
            for (i = 1; i < N_SLOTS; i++) begin
              if (tbl_slot[i].packets < tbl_slot[weakest].packets) weakest = i;
            end
            if (it.packets > tbl_slot[weakest].packets) begin
              hit_at = weakest;
              tbl_slot[hit_at] = '{it.mhz, it.packets, it.rssi, it.rate};
            end
          end
        end
      end
      KIND_READ: begin
        if (it.idx < tbl_used) hit_at = int'(it.idx);
      end
      KIND_CLEAR: begin
        tbl_used = 0;
        tbl_total = '0;
      end
      default: ;
    endcase
    if (hit_at >= 0) begin
      r.valid   = 1'b1;
      r.mhz     = tbl_slot[hit_at].mhz;
      r.packets = tbl_slot[hit_at].packets;
      r.rssi    = tbl_slot[hit_at].rssi;
      r.rate    = tbl_slot[hit_at].rate;
    end
    r.count = tbl_used[4:0];
    r.total = tbl_total;
    return r;
  endfunction

  function automatic string report_text(hit_report_t r);
    return $sformatf("valid=%0d mhz=%0d pk=%0d rssi=%0d rate=%0d count=%0d total=%0d",
                     r.valid, r.mhz, r.packets, r.rssi, r.rate, r.count, r.total);
  endfunction

  // random item: mostly records on a channel pool larger than the table
  function automatic hit_item_t pick_item();
    hit_item_t   it;
    int unsigned roll;
    int unsigned pk_roll;
    it.kind    = 2'($urandom_range(0, 3));
    it.mhz     = 12'($urandom_range(0, 4095));
    it.packets = 16'($urandom_range(0, 65535));
    it.rssi    = 7'($urandom_range(0, 127));
    it.rate    = 2'($urandom_range(0, 3));
    it.idx     = 4'($urandom_range(0, 15));
    roll = $urandom_range(0, 999);
    // noise: every field random, but no clear so the table can fill
    if (roll < 70) begin
      if (it.kind == KIND_CLEAR) it.kind = KIND_UNUSED;
      return it;
    end
    if (roll < 78) begin
      it.kind = KIND_CLEAR;
      return it;
    end
    if (roll < 300) begin
      it.kind = KIND_READ;
      return it;
    end
    it.kind = KIND_RECORD;
    it.mhz  = ($urandom_range(0, 19) == 0) ? 12'(2400 + $urandom_range(0, 100))
                                            : 12'(2400 + $urandom_range(0, 24));
    it.rate = 2'($urandom_range(1, 2));
    pk_roll = $urandom_range(0, 99);
    if (pk_roll < 3) it.packets = 16'd0;
    else if (pk_roll < 8) it.packets = 16'hFFFF;
    else if (pk_roll < 45) it.packets = 16'($urandom_range(1, 64));
    else if (pk_roll < 85) it.packets = 16'($urandom_range(1, 2000));
    else it.packets = 16'($urandom_range(1, 65535));
    return it;
  endfunction

  // sender pause: wait until every expected result has come back
  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || report_q.size() != 0) @(posedge clk);
  endtask

  // driver: offers pending items with random gaps, predicts on acceptance
  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        report_q.push_back(table_update(cur));
        offer = 1'b0;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 14);
      end
      if (!offer) begin
        if (send_gap > 0) send_gap--;
        else if (pending.size() > 0) begin
          cur <= pending.pop_front();
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // monitor: random stalls, one long hold-off, in-order compare
  always @(posedge clk) begin
    hit_report_t got;
    hit_report_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      stall_long = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_entry_valid, out_mhz, out_packets, out_rssi, out_rate,
                out_hit_count, out_hit_total};
        results_seen++;
        if (report_q.size() == 0) begin
          bad++;
          if (bad <= 10) $display("result with nothing expected: %s", report_text(got));
        end else begin
          want = report_q.pop_front();
          if (got !== want) begin
            bad++;
            if (bad <= 10) begin
              $display("mismatch at result %0d", results_seen);
              $display("  expected %s", report_text(want));
              $display("  actual   %s", report_text(got));
            end
          end
        end
        if ($urandom_range(0, 39) == 0) rcv_burst = !rcv_burst;
        stall_left = rcv_burst ? 0 : $urandom_range(0, 14);
        if (results_seen == 700) stall_long = LONG_HOLD;
      end
      if (stall_long > 0) begin
        stall_long--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    int b;
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, unused kind, zero packets, field extremes, saturation
    pending.push_back('{KIND_READ,   12'd0,    16'd0,      7'd0,   2'd0, 4'd0});
    pending.push_back('{KIND_UNUSED, 12'd4095, 16'hFFFF,   7'd127, 2'd3, 4'd15});
    pending.push_back('{KIND_RECORD, 12'd2450, 16'd0,      7'd10,  2'd1, 4'd0});
    pending.push_back('{KIND_RECORD, 12'd2400, 16'hFFFF,   7'd127, 2'd1, 4'd0});
    pending.push_back('{KIND_RECORD, 12'd2400, 16'd1,      7'd0,   2'd2, 4'd0});
    pending.push_back('{KIND_RECORD, 12'd4095, 16'd1,      7'd0,   2'd3, 4'd0});
    pending.push_back('{KIND_RECORD, 12'd0,    16'hAAAA,   7'h55,  2'd0, 4'd0});
    pending.push_back('{KIND_RECORD, 12'd2500, 16'h5555,   7'h2A,  2'd2, 4'd0});
    pending.push_back('{KIND_READ,   12'd0,    16'd0,      7'd0,   2'd0, 4'd0});
    pending.push_back('{KIND_READ,   12'd0,    16'd0,      7'd0,   2'd0, 4'd3});
    pending.push_back('{KIND_READ,   12'd0,    16'd0,      7'd0,   2'd0, 4'd4});
    pending.push_back('{KIND_READ,   12'd0,    16'd0,      7'd0,   2'd0, 4'd15});
    pending.push_back('{KIND_RECORD, 12'd4095, 16'hFFFF,   7'd64,  2'd1, 4'd0});
    pending.push_back('{KIND_READ,   12'd0,    16'd0,      7'd0,   2'd0, 4'd1});
    pending.push_back('{KIND_CLEAR,  12'd0,    16'd0,      7'd0,   2'd0, 4'd0});
    pending.push_back('{KIND_READ,   12'd0,    16'd0,      7'd0,   2'd0, 4'd0});
    pending.push_back('{KIND_RECORD, 12'd2401, 16'd7,      7'd9,   2'd1, 4'd0});
    wait_idle();

    // random batches, each followed by a full drain
    for (b = 0; b < 3; b++) begin
      for (k = 0; k < BATCH_ITEMS; k++) pending.push_back(pick_item());
      wait_idle();
    end

    // let the back end settle, then give the verdict
    repeat (2 * N_SLOTS + 8) @(posedge clk);
    if (bad == 0 && report_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
